[rtl/tlv_three_channel_demux_assert.svh]
// Assertion macros for the TLV demux. Sampled on clk, off while rst_n is low.
`ifndef TLV_THREE_CHANNEL_DEMUX_ASSERT_SVH
`define TLV_THREE_CHANNEL_DEMUX_ASSERT_SVH

// Same-cycle implication.
`define TLVD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tlvd_pkg.sv]
// ----------------------------------------------------------------------------
// tlvd_pkg
// Types, constants and pointer helpers shared by the TLV demux modules.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  localparam int RING_DEPTH = 16384;
  localparam int PTR_W      = $clog2(2 * RING_DEPTH);
  localparam int STORE_DEPTH = 3 * RING_DEPTH;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int NUM_CH     = 3;

  localparam logic [1:0] CH_NONE = 2'd3;   // no such channel
  localparam logic [1:0] CH_LAST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TAG_FIRST  = 2'd0;
  localparam logic [1:0] REG_TAG_SECOND = 2'd1;
  localparam logic [1:0] REG_TAG_THIRD  = 2'd2;

  localparam logic [7:0] TAG_FIRST_RST  = 8'h01;
  localparam logic [7:0] TAG_SECOND_RST = 8'h02;
  localparam logic [7:0] TAG_THIRD_RST  = 8'hfe;

  localparam logic CMD_STREAM = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_LEN_HI  = 4'b0010,
    PH_LEN_LO  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic [1:0] read_channel;
  } in_t;

  typedef struct packed {
    logic        frame_done;
    logic [1:0]  done_channel;
    logic [15:0] done_length;
    logic        done_overflow;
    logic        tag_skipped;
    logic [7:0]  read_data;
    logic        read_valid;
  } out_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t lastp;
    lastp = PTR_W'(2 * RING_DEPTH - 1);
    return (p == lastp) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [1:0] ch, input ptr_t p);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] idx;
    unique case (ch)
      2'd0:    base = '0;
      2'd1:    base = ADDR_W'(RING_DEPTH);
      default: base = ADDR_W'(2 * RING_DEPTH);
    endcase
    idx = (p >= PTR_W'(RING_DEPTH)) ? ADDR_W'(p - PTR_W'(RING_DEPTH)) : ADDR_W'(p);
    return base + idx;
  endfunction

  function automatic logic ring_full(input ptr_t w, input ptr_t r);
    logic [PTR_W:0] used;
    if (w >= r) used = {1'b0, w} - {1'b0, r};
    else        used = {1'b0, w} + (PTR_W+1)'(2 * RING_DEPTH) - {1'b0, r};
    return used >= (PTR_W+1)'(RING_DEPTH);
  endfunction

endpackage

[rtl/tlv_three_channel_demux.sv]
// ----------------------------------------------------------------------------
// tlv_three_channel_demux
// Tag-length-value deframer for three channels with ring storage per channel.
// ----------------------------------------------------------------------------
// A transaction's ring RAM read and its result are registered into the RAM
//   stage on accept, then move on, read byte merged, into the out register.
// Throughput: one transaction per cycle while in_stall is low; the single-port
//   ring RAM sees at most one access per transaction. in_stall rises only when
//   the out register is held by out_stall and the RAM stage is full.
// Reset (rst_n low, synchronous): parser, pointers and tags return to their
//   defaults; the ring RAM is not cleared, only committed bytes are ever read
//   back.
module tlv_three_channel_demux (
  input  logic           clk,
  input  logic           rst_n,
  // input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  tlvd_pkg::in_t  in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output tlvd_pkg::out_t out_data,
  // configuration
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata
);

  `include "tlv_three_channel_demux_assert.svh"

  logic               accept;
  tlvd_pkg::ram_req_t ram_req;
  tlvd_pkg::out_t     ctrl_res;
  logic [7:0]         ram_rdata;

  // RAM stage: holds the transaction whose ring read data is on ram_rdata.
  // The RAM is only accessed on accept, so ram_rdata holds while this stalls.
  logic               s1_valid_r;
  tlvd_pkg::out_t     s1_res_r;
  logic               s1_adv;
  tlvd_pkg::out_t     s1_out;       // RAM stage result with the read byte merged

  // output register
  logic               out_valid_r;
  tlvd_pkg::out_t     out_res_r;
  logic               out_status;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  tlvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .res       (ctrl_res)
  );

  // all three rings share one store, channel c at offset c * RING_DEPTH
  tlvd_ram #(
    .WIDTH (8),
    .DEPTH (tlvd_pkg::STORE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // drained byte is only meaningful on a valid read
  always_comb begin
    s1_out           = s1_res_r;
    s1_out.read_data = s1_res_r.read_valid ? ram_rdata : 8'h00;
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= ctrl_res;
    end
    if (s1_adv) begin
      out_res_r <= s1_out;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_res_r;
  assign out_status = out_data.frame_done || out_data.tag_skipped;

  // RAM stage may only stall when no new RAM access can disturb its read data
  `TLVD_ASSERT_IMPL(a_s1_hold_no_ram, s1_valid_r && !s1_adv, !ram_req.en, "ram access on hold")
  // an accepted transaction never lands on a RAM stage that is not moving on
  `TLVD_ASSERT_IMPL(a_no_overrun, accept, !s1_valid_r || s1_adv, "RAM stage overrun")
  // a drained byte never comes with parser status
  `TLVD_ASSERT_IMPL(a_read_excl, out_valid && out_data.read_valid, !out_status, "read with status")
  // an advance always fills the output register
  `TLVD_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r, "output register not filled")

endmodule

[rtl/tlvd_ram.sv]
// ----------------------------------------------------------------------------
// tlvd_ram
// Generic single-port RAM, registered read, write takes priority.
// ----------------------------------------------------------------------------
module tlvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tlvd_ctrl.sv]
// ----------------------------------------------------------------------------
// tlvd_ctrl
// Frame parser, tag registers and per-channel ring pointers. Issues the ring
// access for each transaction and produces its result (less the read byte).
// ----------------------------------------------------------------------------
module tlvd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  tlvd_pkg::in_t        in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  output tlvd_pkg::ram_req_t   ram_req,
  output tlvd_pkg::out_t       res
);

  logic [7:0] tag0_r, tag1_r, tag2_r;

  tlvd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  cur_r, cur_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;

  tlvd_pkg::ptr_t wp_r [tlvd_pkg::NUM_CH];
  tlvd_pkg::ptr_t cp_r [tlvd_pkg::NUM_CH];
  tlvd_pkg::ptr_t rp_r [tlvd_pkg::NUM_CH];
  tlvd_pkg::ptr_t wp_nxt [tlvd_pkg::NUM_CH];
  tlvd_pkg::ptr_t cp_nxt [tlvd_pkg::NUM_CH];
  tlvd_pkg::ptr_t rp_nxt [tlvd_pkg::NUM_CH];

  always_comb begin
    logic [1:0]     ch;
    logic [1:0]     rc;
    logic [15:0]    cnt_inc;
    logic [15:0]    len_full;
    tlvd_pkg::ptr_t wp_new;

    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    wp_nxt    = wp_r;
    cp_nxt    = cp_r;
    rp_nxt    = rp_r;
    ram_req   = '0;
    res       = '0;

    ch       = (cur_r == tlvd_pkg::CH_NONE) ? tlvd_pkg::CH_LAST : cur_r;
    rc       = in_item.read_channel;
    cnt_inc  = cnt_r + 16'd1;
    len_full = {len_r[15:8], in_item.in_byte};
    wp_new   = wp_r[ch];

    if (accept) begin
      if (in_item.cmd == tlvd_pkg::CMD_READ) begin
        if (rc != tlvd_pkg::CH_NONE && rp_r[rc] != cp_r[rc]) begin
          res.read_valid = 1'b1;
          ram_req.en     = 1'b1;
          ram_req.addr   = tlvd_pkg::ptr_slot(rc, rp_r[rc]);
          rp_nxt[rc]     = tlvd_pkg::ptr_next(rp_r[rc]);
        end
      end else begin
        unique case (phase_r)
          tlvd_pkg::PH_HUNT: begin
            priority if (in_item.in_byte == tag0_r) cur_nxt = 2'd0;
            else if (in_item.in_byte == tag1_r) cur_nxt = 2'd1;
            else if (in_item.in_byte == tag2_r) cur_nxt = 2'd2;
            else res.tag_skipped = 1'b1;
            if (!res.tag_skipped) begin
              phase_nxt = tlvd_pkg::PH_LEN_HI;
              len_nxt   = '0;
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
          end
          tlvd_pkg::PH_LEN_HI: begin
            len_nxt   = {in_item.in_byte, 8'h00};
            phase_nxt = tlvd_pkg::PH_LEN_LO;
          end
          tlvd_pkg::PH_LEN_LO: begin
            len_nxt = len_full;
            cnt_nxt = '0;
            if (len_full == 16'd0) begin
              // empty frame: report, commit nothing
              res.frame_done   = 1'b1;
              res.done_channel = cur_r;
              phase_nxt        = tlvd_pkg::PH_HUNT;
            end else begin
              phase_nxt = tlvd_pkg::PH_PAYLOAD;
            end
          end
          tlvd_pkg::PH_PAYLOAD: begin
            if (tlvd_pkg::ring_full(wp_r[ch], rp_r[ch])) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_req.en    = 1'b1;
              ram_req.we    = 1'b1;
              ram_req.addr  = tlvd_pkg::ptr_slot(ch, wp_r[ch]);
              ram_req.wdata = in_item.in_byte;
              wp_new        = tlvd_pkg::ptr_next(wp_r[ch]);
              wp_nxt[ch]    = wp_new;
            end
            cnt_nxt = cnt_inc;
            if (cnt_inc >= len_r) begin
              cp_nxt[ch]        = wp_new;
              res.frame_done    = 1'b1;
              res.done_channel  = ch;
              res.done_length   = len_r;
              res.done_overflow = ovf_nxt;
              phase_nxt         = tlvd_pkg::PH_HUNT;
              cnt_nxt           = '0;
            end
          end
          default: phase_nxt = tlvd_pkg::PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r  <= tlvd_pkg::TAG_FIRST_RST;
      tag1_r  <= tlvd_pkg::TAG_SECOND_RST;
      tag2_r  <= tlvd_pkg::TAG_THIRD_RST;
      phase_r <= tlvd_pkg::PH_HUNT;
      cur_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < tlvd_pkg::NUM_CH; i++) begin
        wp_r[i] <= '0;
        cp_r[i] <= '0;
        rp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tlvd_pkg::REG_TAG_FIRST:  tag0_r <= cfg_wdata;
          tlvd_pkg::REG_TAG_SECOND: tag1_r <= cfg_wdata;
          tlvd_pkg::REG_TAG_THIRD:  tag2_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      wp_r    <= wp_nxt;
      cp_r    <= cp_nxt;
      rp_r    <= rp_nxt;
    end
  end

endmodule

[verif/tlv_three_channel_demux_checker.sv]
// ----------------------------------------------------------------------------
// tlv_three_channel_demux_checker
// Watches the input, result and register ports of the TLV demux. It keeps its
// own copy of the parser, the rings and the tags, predicts one result per
// accepted transaction and compares each accepted result, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tlv_three_channel_demux_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  tlvd_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  tlvd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  output int             fail_count,
  output int             pending,
  output int             n_frames,
  output int             n_overflow,
  output int             n_skips,
  output int             n_reads
);

  localparam int SPAN = 2 * tlvd_pkg::RING_DEPTH;   // pointer range, wrap bit included

  logic [7:0]       tag_reg [3];
  tlvd_pkg::phase_t parse_phase;
  logic [1:0]       cur_ch;
  logic [15:0]      frame_len;
  logic [15:0]      pay_cnt;
  logic             frame_ovf;
  logic [7:0]       ring_mem [tlvd_pkg::STORE_DEPTH];
  tlvd_pkg::ptr_t   wr_ptr [3];
  tlvd_pkg::ptr_t   cm_ptr [3];
  tlvd_pkg::ptr_t   rd_ptr [3];
  tlvd_pkg::out_t   result_q [$];
  int               mismatches;
  int               strays;
  int               n_checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    n_frames   = 0;
    n_overflow = 0;
    n_skips    = 0;
    n_reads    = 0;
    mismatches = 0;
    strays     = 0;
    n_checked  = 0;
  end

  function automatic tlvd_pkg::ptr_t ptr_inc(input tlvd_pkg::ptr_t p);
    return tlvd_pkg::ptr_t'((int'(p) + 1) % SPAN);
  endfunction

  function automatic int slot_of(input logic [1:0] ch, input tlvd_pkg::ptr_t p);
    return int'(ch) * tlvd_pkg::RING_DEPTH + int'(p) % tlvd_pkg::RING_DEPTH;
  endfunction

  // Advances the model by one transaction and returns its result.
  function automatic tlvd_pkg::out_t demux_next(input tlvd_pkg::in_t t);
    tlvd_pkg::out_t r;
    logic [1:0]     ch;
    int             fill;
    r = '0;
    if (t.cmd == tlvd_pkg::CMD_READ) begin
      ch = t.read_channel;
      if (ch != tlvd_pkg::CH_NONE && rd_ptr[ch] != cm_ptr[ch]) begin
        r.read_data  = ring_mem[slot_of(ch, rd_ptr[ch])];
        r.read_valid = 1'b1;
        rd_ptr[ch]   = ptr_inc(rd_ptr[ch]);
      end
    end else begin
      case (parse_phase)
        tlvd_pkg::PH_HUNT: begin
          // lowest matching channel wins
          if (t.in_byte == tag_reg[0]) cur_ch = 2'd0;
          else if (t.in_byte == tag_reg[1]) cur_ch = 2'd1;
          else if (t.in_byte == tag_reg[2]) cur_ch = 2'd2;
          else r.tag_skipped = 1'b1;
          if (!r.tag_skipped) begin
            parse_phase = tlvd_pkg::PH_LEN_HI;
            frame_len   = '0;
            pay_cnt     = '0;
            frame_ovf   = 1'b0;
          end
        end
        tlvd_pkg::PH_LEN_HI: begin
          frame_len   = {t.in_byte, 8'h00};
          parse_phase = tlvd_pkg::PH_LEN_LO;
        end
        tlvd_pkg::PH_LEN_LO: begin
          frame_len[7:0] = t.in_byte;
          pay_cnt        = '0;
          if (frame_len == 16'd0) begin
            // empty frame: reported, nothing committed
            r.frame_done   = 1'b1;
            r.done_channel = cur_ch;
            parse_phase    = tlvd_pkg::PH_HUNT;
          end else begin
            parse_phase = tlvd_pkg::PH_PAYLOAD;
          end
        end
        default: begin  // payload
          ch   = (cur_ch > tlvd_pkg::CH_LAST) ? tlvd_pkg::CH_LAST : cur_ch;
          fill = (int'(wr_ptr[ch]) - int'(rd_ptr[ch]) + SPAN) % SPAN;
          if (fill >= tlvd_pkg::RING_DEPTH) begin
            frame_ovf = 1'b1;  // byte dropped, still counted
          end else begin
            ring_mem[slot_of(ch, wr_ptr[ch])] = t.in_byte;
            wr_ptr[ch] = ptr_inc(wr_ptr[ch]);
          end
          pay_cnt = pay_cnt + 16'd1;
          if (pay_cnt >= frame_len) begin
            cm_ptr[ch]      = wr_ptr[ch];
            r.frame_done    = 1'b1;
            r.done_channel  = ch;
            r.done_length   = frame_len;
            r.done_overflow = frame_ovf;
            parse_phase     = tlvd_pkg::PH_HUNT;
            pay_cnt         = '0;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic void flag_field(input string name, input logic [15:0] want_v,
                                     input logic [15:0] got_v);
    mismatches++;
    if (mismatches + strays <= 10)
      $display("checker: result %0d, %s expected %0h got %0h",
               n_checked, name, want_v, got_v);
  endfunction

  always @(posedge clk) begin : watch
    tlvd_pkg::out_t want;
    if (!rst_n) begin
      tag_reg[0]  = tlvd_pkg::TAG_FIRST_RST;
      tag_reg[1]  = tlvd_pkg::TAG_SECOND_RST;
      tag_reg[2]  = tlvd_pkg::TAG_THIRD_RST;
      parse_phase = tlvd_pkg::PH_HUNT;
      cur_ch      = '0;
      frame_len   = '0;
      pay_cnt     = '0;
      frame_ovf   = 1'b0;
      for (int i = 0; i < 3; i++) begin
        wr_ptr[i] = '0;
        cm_ptr[i] = '0;
        rd_ptr[i] = '0;
      end
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlvd_pkg::REG_TAG_FIRST:  tag_reg[0] = cfg_wdata;
          tlvd_pkg::REG_TAG_SECOND: tag_reg[1] = cfg_wdata;
          tlvd_pkg::REG_TAG_THIRD:  tag_reg[2] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        result_q.push_back(demux_next(in_data));
      if (out_valid && !out_stall) begin
        n_checked++;
        if (result_q.size() == 0) begin
          strays++;
          if (mismatches + strays <= 10)
            $display("checker: result %0d arrived with nothing expected (%h)",
                     n_checked, out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.frame_done !== want.frame_done)
            flag_field("frame_done", want.frame_done, out_data.frame_done);
          if (out_data.done_channel !== want.done_channel)
            flag_field("done_channel", want.done_channel, out_data.done_channel);
          if (out_data.done_length !== want.done_length)
            flag_field("done_length", want.done_length, out_data.done_length);
          if (out_data.done_overflow !== want.done_overflow)
            flag_field("done_overflow", want.done_overflow, out_data.done_overflow);
          if (out_data.tag_skipped !== want.tag_skipped)
            flag_field("tag_skipped", want.tag_skipped, out_data.tag_skipped);
          if (out_data.read_data !== want.read_data)
            flag_field("read_data", want.read_data, out_data.read_data);
          if (out_data.read_valid !== want.read_valid)
            flag_field("read_valid", want.read_valid, out_data.read_valid);
          if (want.frame_done) n_frames++;
          if (want.done_overflow) n_overflow++;
          if (want.tag_skipped) n_skips++;
          if (want.read_valid) n_reads++;
        end
      end
    end
    pending    = result_q.size();
    fail_count = mismatches + strays;
  end

endmodule

[verif/tlv_three_channel_demux_tb.sv]
// ----------------------------------------------------------------------------
// tlv_three_channel_demux_tb
// Stimulus and verdict for the three-channel TLV demux. A directed opener,
// then random frame traffic under several tag settings. Prediction and
// comparison live in the checker.
// ----------------------------------------------------------------------------
module tlv_three_channel_demux_tb;

  // The watchdog limit sits well above the slowest legal run (about 1300
  // transactions, each at worst a sender gap plus a receiver stall run, plus
  // the hold-offs).
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int ROUND_ITEMS = 300;       // random transactions per tag setting

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  tlvd_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  tlvd_pkg::out_t out_data;
  logic           cfg_we;
  logic [1:0]     cfg_index;
  logic [7:0]     cfg_wdata;

  int fail_count, pending, n_frames, n_overflow, n_skips, n_reads;

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned settings_used;
  int unsigned holds_done;
  bit          hold_req;
  logic [7:0]  tag_val [3];   // tags currently programmed, for frame generation

  tlv_three_channel_demux i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tlv_three_channel_demux_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_frames   (n_frames),
    .n_overflow (n_overflow),
    .n_skips    (n_skips),
    .n_reads    (n_reads)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("watchdog: no end after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver pacing. Runs of random length in one of several stall densities,
  // and on request a long hold-off so the pipeline backs up into in_stall.
  // Exactly one assignment to out_stall per falling edge.
  initial begin : rx_pacing
    int unsigned mode;
    int unsigned span;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;                       // free flowing
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Offers one transaction and returns at the falling edge after it was
  // accepted. The sender works in bursts; a burst is preceded by a random gap
  // (sometimes none, so back-to-back bursts also occur).
  task automatic offer(input tlvd_pkg::in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Stream byte; read_channel is don't-care here and gets random bits.
  task automatic put_byte(input logic [7:0] b);
    tlvd_pkg::in_t item;
    item.cmd          = tlvd_pkg::CMD_STREAM;
    item.in_byte      = b;
    item.read_channel = 2'($urandom);
    offer(item);
  endtask

  // Read command; in_byte is don't-care here and gets random bits.
  task automatic put_read(input logic [1:0] ch);
    tlvd_pkg::in_t item;
    item.cmd          = tlvd_pkg::CMD_READ;
    item.in_byte      = 8'($urandom);
    item.read_channel = ch;
    offer(item);
  endtask

  // Tag, big-endian length, random payload. With mix_reads, reads of random
  // channels are slipped in between payload bytes (reads during a frame).
  task automatic put_frame(input logic [7:0] tag, input logic [15:0] len,
                           input bit mix_reads);
    int unsigned k;
    put_byte(tag);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (k = 0; k < len; k++) begin
      if (mix_reads && $urandom_range(0, 9) == 0)
        put_read(2'($urandom_range(0, 3)));
      put_byte(8'($urandom));
    end
  endtask

  // Drop valid and wait until every predicted result has come back. Every
  // transaction yields a result, so nothing is in flight after that.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Writes all three tag registers, one per cycle; call only when idle.
  task automatic set_tags(input logic [7:0] t0, input logic [7:0] t1,
                          input logic [7:0] t2);
    tag_val[0] = t0;
    tag_val[1] = t1;
    tag_val[2] = t2;
    cfg_we    <= 1'b1;
    cfg_index <= tlvd_pkg::REG_TAG_FIRST;
    cfg_wdata <= t0;
    @(negedge clk);
    cfg_index <= tlvd_pkg::REG_TAG_SECOND;
    cfg_wdata <= t1;
    @(negedge clk);
    cfg_index <= tlvd_pkg::REG_TAG_THIRD;
    cfg_wdata <= t2;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Mostly well-formed frames on the programmed tags, plus read bursts on all
  // four channel codes and junk bytes in the hunt state that never match a tag
  // (a chance match would open a frame of random, possibly huge, length).
  task automatic random_round(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    logic [7:0]  junk;
    start    = items_sent;
    hold_req = 1'b1;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 99);
        if (n < 5)      len = 16'd0;
        else if (n < 9) len = 16'($urandom_range(256, 280));
        else            len = 16'($urandom_range(1, 24));
        put_frame(tag_val[$urandom_range(0, 2)], len, 1'b1);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) put_read(2'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          do junk = 8'($urandom);
          while (junk == tag_val[0] || junk == tag_val[1] || junk == tag_val[2]);
          put_byte(junk);
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = tlvd_pkg::REG_TAG_FIRST;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    settings_used = 0;
    holds_done    = 0;
    tag_val[0]    = tlvd_pkg::TAG_FIRST_RST;
    tag_val[1]    = tlvd_pkg::TAG_SECOND_RST;
    tag_val[2]    = tlvd_pkg::TAG_THIRD_RST;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed opener, reset tags ----
    put_byte(8'h00);                       // neither extreme is a tag: skipped
    put_byte(8'hff);
    put_frame(tlvd_pkg::TAG_FIRST_RST, 16'd0, 1'b0); // empty frame, nothing committed
    put_byte(tlvd_pkg::TAG_SECOND_RST);    // channel 1, payload 00 ff
    put_byte(8'h00);
    put_byte(8'h02);
    put_byte(8'h00);
    put_byte(8'hff);
    put_frame(tlvd_pkg::TAG_THIRD_RST, 16'd1, 1'b0); // channel 2, one byte
    put_byte(tlvd_pkg::TAG_FIRST_RST);     // channel 0 frame with reads inside
    put_byte(8'h00);
    put_read(2'd2);                        // committed data while mid-frame
    put_byte(8'h01);
    put_read(2'd0);                        // nothing committed yet: empty
    put_byte(8'h5a);
    put_read(2'd1);
    put_read(2'd1);
    put_read(2'd1);                        // drained: empty
    put_read(tlvd_pkg::CH_NONE);           // no such channel: empty
    put_read(2'd0);
    settle();

    // ---- random traffic under several tag settings ----
    // extremes; first and third equal, so channel 2 is shadowed
    set_tags(8'h00, 8'hff, 8'h00);
    random_round(ROUND_ITEMS);
    settle();
    // all three equal: everything lands on channel 0
    set_tags(8'hff, 8'hff, 8'hff);
    random_round(ROUND_ITEMS);
    settle();
    set_tags(8'($urandom), 8'($urandom), 8'($urandom));
    random_round(ROUND_ITEMS);
    settle();
    set_tags(8'h7e, 8'h00, 8'hff);
    random_round(ROUND_ITEMS);
    settle();

    // results are done; let the clock run on so that strays show
    repeat (8) @(negedge clk);
    $display("run: %0d transactions over %0d tag settings, %0d receiver hold-offs",
             items_sent, settings_used, holds_done);
    $display("run: %0d frames (%0d overflowed), %0d bytes skipped, %0d bytes read back",
             n_frames, n_overflow, n_skips, n_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tlvd_pkg.sv
rtl/tlvd_ram.sv
rtl/tlvd_ctrl.sv
rtl/tlv_three_channel_demux.sv
verif/tlv_three_channel_demux_checker.sv
verif/tlv_three_channel_demux_tb.sv
